// ----- design/gctt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gctt_pkg;

  localparam int unsigned TIMER_ID_W = 10;
  localparam int unsigned MS_W       = 20;
  localparam int unsigned PROD_W     = 32 + MS_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [MS_W-1:0] MS_TO_NS = MS_W'(1000000);

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_POLL  = 2'd1;
  localparam logic [1:0] ACT_WAIT  = 2'd2;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_PENDING = 3'd2;
  localparam logic [2:0] ST_BAD     = 3'd3;
  localparam logic [2:0] ST_STALE   = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef enum logic [1:0] {
    K_START,
    K_POLL,
    K_WAIT
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [PROD_W-1:0]  delay_prod;
    logic [31:0]        hid;
    logic [31:0]        hseq;
    logic [63:0]        now;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- design/gctt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gctt_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_action,
  input  wire logic [31:0]       in_delay_ms,
  input  wire logic [31:0]       in_handle_id,
  input  wire logic [31:0]       in_handle_seq,
  input  wire logic [63:0]       in_current_time_ns,
  input  wire gctt_pkg::q_status_t q_status,
  output logic                   q_push,
  output gctt_pkg::q_item_t      q_item
);
  import gctt_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  q_item_t item_r;
  q_item_t item_nxt;
  logic    accept;
  logic    keep;

  assign q_push   = valid_r && !q_status.full;
  assign in_stall = valid_r && q_status.full;
  assign accept   = in_valid && !in_stall;
  assign q_item   = item_r;

  always_comb begin
    keep              = 1'b1;
    item_nxt          = item_r;
    item_nxt.delay_prod = PROD_W'(in_delay_ms) * PROD_W'(MS_TO_NS);
    item_nxt.hid      = in_handle_id;
    item_nxt.hseq     = in_handle_seq;
    item_nxt.now      = in_current_time_ns;
    unique case (in_action)
      ACT_START: item_nxt.kind = K_START;
      ACT_POLL:  item_nxt.kind = K_POLL;
      ACT_WAIT:  item_nxt.kind = K_WAIT;
      default: begin
        item_nxt.kind = K_POLL;
        keep          = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (q_push) begin
      valid_nxt = 1'b0;
    end
    if (accept && keep) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/gctt_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gctt_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire gctt_pkg::q_item_t push_item,
  input  wire logic              pop,
  output gctt_pkg::q_item_t      head_item,
  output gctt_pkg::q_status_t    status
);
  import gctt_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_item    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("Queue written while full.");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("Queue read while empty.");

endmodule

`default_nettype wire

// ----- design/gctt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gctt_back #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gctt_pkg::q_item_t                 q_item,
  input  wire gctt_pkg::q_status_t               q_status,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [2:0]                             out_status,
  output logic [gctt_pkg::TIMER_ID_W-1:0]        out_timer_id,
  output logic [31:0]                            out_timer_seq,
  output logic [63:0]                            out_wait_remaining_ns
);
  import gctt_pkg::*;

  localparam int unsigned ID_W  = $clog2(SLOT_COUNT);
  localparam int unsigned NXT_W = ID_W + 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } bstate_t;

  logic [31:0]             seq_mem [SLOT_COUNT];
  logic [63:0]             due_mem [SLOT_COUNT];
  logic [31:0]             seq_rd_r;
  logic [63:0]             due_rd_r;

  bstate_t                 state_r;
  bstate_t                 state_nxt;
  q_item_t                 work_r;
  logic [NXT_W-1:0]        next_id_r;
  logic [NXT_W-1:0]        next_id_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [2:0]              out_status_r;
  logic [TIMER_ID_W-1:0]   out_timer_id_r;
  logic [31:0]             out_timer_seq_r;
  logic [63:0]             out_remaining_r;

  logic                    load;
  logic                    seq_we;
  logic                    due_we;
  logic [ID_W-1:0]         wr_idx;
  logic [31:0]             wr_seq;
  logic [64:0]             due_sum;
  logic [63:0]             due_new;
  logic [31:0]             new_seq;
  logic                    full;
  logic                    bad;
  logic                    stale;
  logic [2:0]              status_nxt;
  logic [TIMER_ID_W-1:0]   timer_id_nxt;
  logic [31:0]             timer_seq_nxt;
  logic [63:0]             remaining_nxt;

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_timer_id          = out_timer_id_r;
  assign out_timer_seq         = out_timer_seq_r;
  assign out_wait_remaining_ns = out_remaining_r;

  assign due_sum = {1'b0, work_r.now} + 65'(work_r.delay_prod);
  assign due_new = due_sum[64] ? '1 : due_sum[63:0];
  assign new_seq = work_r.hseq + 32'd1;
  assign full    = (next_id_r >= NXT_W'(SLOT_COUNT));
  assign bad     = (work_r.hid == 32'd0) || (work_r.hid >= 32'(next_id_r));
  assign stale   = (seq_rd_r != work_r.hseq);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    seq_we        = 1'b0;
    due_we        = 1'b0;
    wr_idx        = work_r.hid[ID_W-1:0];
    wr_seq        = new_seq;
    next_id_nxt   = next_id_r;
    status_nxt    = ST_BAD;
    timer_id_nxt  = '0;
    timer_seq_nxt = '0;
    remaining_nxt = '0;
    if (work_r.kind == K_START) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt   = ST_NEW;
        timer_id_nxt = TIMER_ID_W'(next_id_r);
        wr_idx       = next_id_r[ID_W-1:0];
        wr_seq       = 32'd0;
        seq_we       = load;
        due_we       = load;
        if (load) begin
          next_id_nxt = next_id_r + 1'b1;
        end
      end
    end else if (bad) begin
      status_nxt = ST_BAD;
    end else if (stale) begin
      status_nxt = ST_STALE;
    end else begin
      seq_we        = load;
      timer_id_nxt  = TIMER_ID_W'(work_r.hid);
      timer_seq_nxt = new_seq;
      if (work_r.kind == K_WAIT) begin
        status_nxt = ST_READY;
        if (work_r.now < due_rd_r) begin
          remaining_nxt = due_rd_r - work_r.now;
        end
      end else begin
        status_nxt = (work_r.now >= due_rd_r) ? ST_READY : ST_PENDING;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      next_id_r   <= NXT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_item;
    end
    if (load) begin
      out_status_r    <= status_nxt;
      out_timer_id_r  <= timer_id_nxt;
      out_timer_seq_r <= timer_seq_nxt;
      out_remaining_r <= remaining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[wr_idx] <= wr_seq;
    end
    if (q_pop) begin
      seq_rd_r <= seq_mem[q_item.hid[ID_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[wr_idx] <= due_new;
    end
    if (q_pop) begin
      due_rd_r <= due_mem[q_item.hid[ID_W-1:0]];
    end
  end

  a_id_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r <= NXT_W'(SLOT_COUNT))
    else $error("Next id ran past the slot count.");

  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    (next_id_r != $past(next_id_r)) |-> (next_id_r == $past(next_id_r) + 1'b1))
    else $error("Next id moved by more than one.");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (state_r == B_EXEC))
    else $error("Result word loaded outside the execute step.");

endmodule

`default_nettype wire

// ----- design/generation_checked_timer_table.sv -----
// Generation-checked one-shot timer table.
// The input channel (in_valid, in_stall) carries one word per request: start a
// timer, poll a handle, or wait on a handle. Action code 3 is dropped and gives
// no result word. Every other request gives exactly one word on the output
// channel (out_valid, out_stall) with status, timer id, sequence and, for wait,
// the nanoseconds still to wait.
// A front stage registers the request and forms delay times one million, a
// two-word queue decouples it from the back end, and the back end reads the
// slot memories, checks the handle and updates the slot.
// The back end takes no new request until the last one has loaded its result
// word, since it reads and then updates the slot memories; that load waits
// while a stalled output word is still held.
// A stalled output word holds its value; the queue and front stage keep taking
// requests until they fill, and then in_stall rises.
// Synchronous reset empties the pipeline and sets the next id to one. The slot
// memories are not cleared, as slot words are only used after start writes them.
`timescale 1ns / 1ps
`default_nettype none

module generation_checked_timer_table #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_action,
  input  wire logic [31:0]                  in_delay_ms,
  input  wire logic [31:0]                  in_handle_id,
  input  wire logic [31:0]                  in_handle_seq,
  input  wire logic [63:0]                  in_current_time_ns,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_status,
  output logic [gctt_pkg::TIMER_ID_W-1:0]   out_timer_id,
  output logic [31:0]                       out_timer_seq,
  output logic [63:0]                       out_wait_remaining_ns
);
  import gctt_pkg::*;

  q_item_t   front_item;
  q_item_t   head_item;
  q_status_t q_status;
  logic      q_push;
  logic      q_pop;

  gctt_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_delay_ms        (in_delay_ms),
    .in_handle_id       (in_handle_id),
    .in_handle_seq      (in_handle_seq),
    .in_current_time_ns (in_current_time_ns),
    .q_status           (q_status),
    .q_push             (q_push),
    .q_item             (front_item)
  );

  gctt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (head_item),
    .status    (q_status)
  );

  gctt_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_item                (head_item),
    .q_status              (q_status),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_timer_id          (out_timer_id),
    .out_timer_seq         (out_timer_seq),
    .out_wait_remaining_ns (out_wait_remaining_ns)
  );

endmodule

`default_nettype wire
